// ===== src/brc_pkg.sv =====
`default_nettype none
package brc_pkg;

   localparam int DIM_BITS_DEFAULT = 16;
   localparam int FIELD_W          = 16;
   localparam int COORD_W          = 32;
   localparam int WIDE_W           = 36;
   localparam int ALPHA_W          = 8;
   localparam int CSR_INDEX_W      = 4;
   localparam int STAGES           = 6;

   localparam logic [ALPHA_W-1:0] ALPHA_CLEAR  = 8'd0;
   localparam logic [ALPHA_W-1:0] ALPHA_OPAQUE = 8'd255;

   localparam logic [CSR_INDEX_W-1:0] CSR_DEST_WIDTH  = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEST_HEIGHT = 4'd1;

   typedef enum logic [1:0] {
      FUNC_FILL  = 2'd0,
      FUNC_COPY  = 2'd1,
      FUNC_BLEND = 2'd2,
      FUNC_RSVD  = 2'd3
   } func_type;

   typedef struct packed {
      func_type                  func;
      logic signed [COORD_W-1:0] dest_corner_x;
      logic signed [COORD_W-1:0] dest_corner_y;
      logic signed [COORD_W-1:0] source_corner_x;
      logic signed [COORD_W-1:0] source_corner_y;
      logic [COORD_W-1:0]        rect_width;
      logic [COORD_W-1:0]        rect_height;
      logic [FIELD_W-1:0]        source_surface_width;
      logic [FIELD_W-1:0]        source_surface_height;
      logic                      same_buffer;
      logic [ALPHA_W-1:0]        blend_alpha;
   } req_type;

   typedef struct packed {
      logic                 skip;
      logic [FIELD_W-1:0]   clip_dest_x;
      logic [FIELD_W-1:0]   clip_dest_y;
      logic [FIELD_W-1:0]   clip_source_x;
      logic [FIELD_W-1:0]   clip_source_y;
      logic [FIELD_W-1:0]   clip_width;
      logic [FIELD_W-1:0]   clip_height;
      logic [COORD_W-1:0]   dest_offset;
      logic [COORD_W-1:0]   source_offset;
      logic                 walk_rows_backward;
      logic                 walk_cols_backward;
      logic                 plain_copy;
   } rsp_type;

   // working geometry, wide signed so no trim step wraps
   typedef struct packed {
      logic signed [WIDE_W-1:0] dx;
      logic signed [WIDE_W-1:0] dy;
      logic signed [WIDE_W-1:0] sx;
      logic signed [WIDE_W-1:0] sy;
      logic signed [WIDE_W-1:0] w;
      logic signed [WIDE_W-1:0] h;
      logic [FIELD_W-1:0]       sw;
      logic [FIELD_W-1:0]       sh;
      logic                     has_src;
      logic                     skip;
      logic                     plain;
      logic                     same;
   } geom_type;

   typedef struct packed {
      logic [FIELD_W-1:0] dw;
      logic [FIELD_W-1:0] dh;
   } dims_type;

   typedef struct packed {
      logic load_a;
      logic load_b;
   } stage_en_type;

   function automatic logic signed [WIDE_W-1:0] widen(input logic signed [COORD_W-1:0] v);
      return WIDE_W'(v);
   endfunction

   function automatic logic not_positive(input logic signed [WIDE_W-1:0] v);
      return v[WIDE_W-1] || (v == '0);
   endfunction

endpackage
`default_nettype wire

// ===== src/brc_if.sv =====
`default_nettype none
interface brc_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [1:0]                            func;
   logic signed [brc_pkg::COORD_W-1:0]    dest_corner_x;
   logic signed [brc_pkg::COORD_W-1:0]    dest_corner_y;
   logic signed [brc_pkg::COORD_W-1:0]    source_corner_x;
   logic signed [brc_pkg::COORD_W-1:0]    source_corner_y;
   logic [brc_pkg::COORD_W-1:0]           rect_width;
   logic [brc_pkg::COORD_W-1:0]           rect_height;
   logic [brc_pkg::FIELD_W-1:0]           source_surface_width;
   logic [brc_pkg::FIELD_W-1:0]           source_surface_height;
   logic                                  same_buffer;
   logic [brc_pkg::ALPHA_W-1:0]           blend_alpha;

   modport source (
      output valid, func, dest_corner_x, dest_corner_y, source_corner_x, source_corner_y,
             rect_width, rect_height, source_surface_width, source_surface_height,
             same_buffer, blend_alpha,
      input  ready
   );
   modport sink (
      input  valid, func, dest_corner_x, dest_corner_y, source_corner_x, source_corner_y,
             rect_width, rect_height, source_surface_width, source_surface_height,
             same_buffer, blend_alpha,
      output ready
   );
endinterface

interface brc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          skip;
   logic [brc_pkg::FIELD_W-1:0]   clip_dest_x;
   logic [brc_pkg::FIELD_W-1:0]   clip_dest_y;
   logic [brc_pkg::FIELD_W-1:0]   clip_source_x;
   logic [brc_pkg::FIELD_W-1:0]   clip_source_y;
   logic [brc_pkg::FIELD_W-1:0]   clip_width;
   logic [brc_pkg::FIELD_W-1:0]   clip_height;
   logic [brc_pkg::COORD_W-1:0]   dest_offset;
   logic [brc_pkg::COORD_W-1:0]   source_offset;
   logic                          walk_rows_backward;
   logic                          walk_cols_backward;
   logic                          plain_copy;

   modport source (
      output valid, skip, clip_dest_x, clip_dest_y, clip_source_x, clip_source_y,
             clip_width, clip_height, dest_offset, source_offset,
             walk_rows_backward, walk_cols_backward, plain_copy,
      input  ready
   );
   modport sink (
      input  valid, skip, clip_dest_x, clip_dest_y, clip_source_x, clip_source_y,
             clip_width, clip_height, dest_offset, source_offset,
             walk_rows_backward, walk_cols_backward, plain_copy,
      output ready
   );
endinterface

interface brc_csr_if;
   logic                              valid;
   logic                              ready;
   logic [brc_pkg::CSR_INDEX_W-1:0]   index;
   logic [brc_pkg::FIELD_W-1:0]       data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== src/blit_rectangle_clipper_core.sv =====
// Pipeline: six register stages; the first loads at the request transfer edge, and
// the result is valid once the command reaches the last stage.
// Throughput: one command per cycle; each stage holds under backpressure and
// refills as soon as the stage ahead moves, so bubbles are squeezed out.
// Reset: synchronous, active high; empties the pipeline and clears the
// destination surface width and height registers to 0.
`default_nettype none
module blit_rectangle_clipper_core #(
   parameter int DIM_BITS = brc_pkg::DIM_BITS_DEFAULT
) (
   input  wire           clock,
   input  wire           reset,
   brc_req_if.sink       req_ch,
   brc_rsp_if.source     rsp_ch,
   brc_csr_if.sink       csr_ch
);

   localparam int DIM_USED = (DIM_BITS < brc_pkg::FIELD_W) ? DIM_BITS : brc_pkg::FIELD_W;

   logic [brc_pkg::FIELD_W-1:0]  dest_width_ff, dest_width_in;
   logic [brc_pkg::FIELD_W-1:0]  dest_height_ff, dest_height_in;
   logic [brc_pkg::STAGES-1:0]   valid_ff, valid_in;
   logic [brc_pkg::STAGES-1:0]   stage_adv;
   brc_pkg::dims_type            dims;
   brc_pkg::req_type             req;
   brc_pkg::geom_type            near_geom, far_geom;
   brc_pkg::rsp_type             rsp;
   brc_pkg::stage_en_type        near_en, far_en, offset_en;

   // configuration
   assign csr_ch.ready = 1'b1;

   always_comb begin
      dest_width_in  = dest_width_ff;
      dest_height_in = dest_height_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            brc_pkg::CSR_DEST_WIDTH:  dest_width_in  = csr_ch.data;
            brc_pkg::CSR_DEST_HEIGHT: dest_height_in = csr_ch.data;
            default: ;
         endcase
      end
   end

   assign dims.dw = brc_pkg::FIELD_W'(dest_width_ff[DIM_USED-1:0]);
   assign dims.dh = brc_pkg::FIELD_W'(dest_height_ff[DIM_USED-1:0]);

   // stage flow control
   always_comb begin
      stage_adv[brc_pkg::STAGES-1] = !valid_ff[brc_pkg::STAGES-1] || rsp_ch.ready;
      for (int k = brc_pkg::STAGES - 2; k >= 0; k--) begin
         stage_adv[k] = !valid_ff[k] || stage_adv[k+1];
      end
      valid_in[0] = stage_adv[0] ? req_ch.valid : valid_ff[0];
      for (int k = 1; k < brc_pkg::STAGES; k++) begin
         valid_in[k] = stage_adv[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= '0;
         dest_width_ff  <= '0;
         dest_height_ff <= '0;
      end else begin
         valid_ff       <= valid_in;
         dest_width_ff  <= dest_width_in;
         dest_height_ff <= dest_height_in;
      end
   end

   assign req_ch.ready = stage_adv[0];

   assign near_en.load_a   = stage_adv[0];
   assign near_en.load_b   = stage_adv[1];
   assign far_en.load_a    = stage_adv[2];
   assign far_en.load_b    = stage_adv[3];
   assign offset_en.load_a = stage_adv[4];
   assign offset_en.load_b = stage_adv[5];

   assign req.func                  = brc_pkg::func_type'(req_ch.func);
   assign req.dest_corner_x         = req_ch.dest_corner_x;
   assign req.dest_corner_y         = req_ch.dest_corner_y;
   assign req.source_corner_x       = req_ch.source_corner_x;
   assign req.source_corner_y       = req_ch.source_corner_y;
   assign req.rect_width            = req_ch.rect_width;
   assign req.rect_height           = req_ch.rect_height;
   assign req.source_surface_width  = req_ch.source_surface_width;
   assign req.source_surface_height = req_ch.source_surface_height;
   assign req.same_buffer           = req_ch.same_buffer;
   assign req.blend_alpha           = req_ch.blend_alpha;

   brc_near_clip #(
      .DIM_BITS (DIM_BITS)
   ) u_near_clip (
      .clock (clock),
      .en    (near_en),
      .req   (req),
      .geom  (near_geom)
   );

   brc_far_clip u_far_clip (
      .clock    (clock),
      .en       (far_en),
      .dims     (dims),
      .geom_in  (near_geom),
      .geom_out (far_geom)
   );

   brc_offset u_offset (
      .clock (clock),
      .en    (offset_en),
      .dims  (dims),
      .geom  (far_geom),
      .rsp   (rsp)
   );

   assign rsp_ch.valid              = valid_ff[brc_pkg::STAGES-1];
   assign rsp_ch.skip               = rsp.skip;
   assign rsp_ch.clip_dest_x        = rsp.clip_dest_x;
   assign rsp_ch.clip_dest_y        = rsp.clip_dest_y;
   assign rsp_ch.clip_source_x      = rsp.clip_source_x;
   assign rsp_ch.clip_source_y      = rsp.clip_source_y;
   assign rsp_ch.clip_width         = rsp.clip_width;
   assign rsp_ch.clip_height        = rsp.clip_height;
   assign rsp_ch.dest_offset        = rsp.dest_offset;
   assign rsp_ch.source_offset      = rsp.source_offset;
   assign rsp_ch.walk_rows_backward = rsp.walk_rows_backward;
   assign rsp_ch.walk_cols_backward = rsp.walk_cols_backward;
   assign rsp_ch.plain_copy         = rsp.plain_copy;

   // a skipped command carries no geometry
   a_skip_clears_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.skip) |-> (rsp_ch.clip_width == '0) &&
         (rsp_ch.clip_height == '0) && (rsp_ch.dest_offset == '0) && !rsp_ch.plain_copy)
      else $error("skipped result carries nonzero fields");

   // a drawn rectangle is never empty
   a_drawn_not_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.skip) |-> (rsp_ch.clip_width != '0) &&
         (rsp_ch.clip_height != '0))
      else $error("drawn result with empty rectangle");

   a_walk_rows_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.walk_rows_backward) |->
         (rsp_ch.clip_dest_y > rsp_ch.clip_source_y))
      else $error("backward row walk without destination below source");

   // a stalled first stage keeps its command
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[0] && !stage_adv[0]) |=> valid_ff[0])
      else $error("stalled stage lost its command");

endmodule
`default_nettype wire

// ===== src/brc_near_clip.sv =====
`default_nettype none
module brc_near_clip #(
   parameter int DIM_BITS = brc_pkg::DIM_BITS_DEFAULT
) (
   input  wire                      clock,
   input  brc_pkg::stage_en_type    en,
   input  brc_pkg::req_type         req,
   output brc_pkg::geom_type        geom
);

   localparam int DIM_USED = (DIM_BITS < brc_pkg::FIELD_W) ? DIM_BITS : brc_pkg::FIELD_W;
   localparam int MSB      = brc_pkg::WIDE_W - 1;

   brc_pkg::geom_type trim_dest_in, trim_dest_ff;
   brc_pkg::geom_type trim_src_in, trim_src_ff;
   logic              has_src;

   // destination near edges: move source along
   always_comb begin
      has_src = (req.func == brc_pkg::FUNC_COPY) || (req.func == brc_pkg::FUNC_BLEND);
      trim_dest_in.dx      = brc_pkg::widen(req.dest_corner_x);
      trim_dest_in.dy      = brc_pkg::widen(req.dest_corner_y);
      trim_dest_in.sx      = has_src ? brc_pkg::widen(req.source_corner_x) : '0;
      trim_dest_in.sy      = has_src ? brc_pkg::widen(req.source_corner_y) : '0;
      trim_dest_in.w       = brc_pkg::WIDE_W'(req.rect_width);
      trim_dest_in.h       = brc_pkg::WIDE_W'(req.rect_height);
      trim_dest_in.sw      = brc_pkg::FIELD_W'(req.source_surface_width[DIM_USED-1:0]);
      trim_dest_in.sh      = brc_pkg::FIELD_W'(req.source_surface_height[DIM_USED-1:0]);
      trim_dest_in.has_src = has_src;
      trim_dest_in.skip    = (req.func == brc_pkg::FUNC_RSVD) ||
                             ((req.func == brc_pkg::FUNC_BLEND) &&
                              (req.blend_alpha == brc_pkg::ALPHA_CLEAR));
      trim_dest_in.plain   = (req.func == brc_pkg::FUNC_COPY) ||
                             ((req.func == brc_pkg::FUNC_BLEND) &&
                              (req.blend_alpha == brc_pkg::ALPHA_OPAQUE));
      trim_dest_in.same    = req.same_buffer;
      if (trim_dest_in.dx[MSB]) begin
         trim_dest_in.w  = trim_dest_in.w + trim_dest_in.dx;
         trim_dest_in.sx = trim_dest_in.sx - trim_dest_in.dx;
         trim_dest_in.dx = '0;
      end
      if (trim_dest_in.dy[MSB]) begin
         trim_dest_in.h  = trim_dest_in.h + trim_dest_in.dy;
         trim_dest_in.sy = trim_dest_in.sy - trim_dest_in.dy;
         trim_dest_in.dy = '0;
      end
   end

   // source near edges: move destination along
   always_comb begin
      trim_src_in = trim_dest_ff;
      if (trim_dest_ff.has_src && trim_dest_ff.sx[MSB]) begin
         trim_src_in.w  = trim_dest_ff.w + trim_dest_ff.sx;
         trim_src_in.dx = trim_dest_ff.dx - trim_dest_ff.sx;
         trim_src_in.sx = '0;
      end
      if (trim_dest_ff.has_src && trim_dest_ff.sy[MSB]) begin
         trim_src_in.h  = trim_dest_ff.h + trim_dest_ff.sy;
         trim_src_in.dy = trim_dest_ff.dy - trim_dest_ff.sy;
         trim_src_in.sy = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en.load_a) begin
         trim_dest_ff <= trim_dest_in;
      end
      if (en.load_b) begin
         trim_src_ff <= trim_src_in;
      end
   end

   assign geom = trim_src_ff;

endmodule
`default_nettype wire

// ===== src/brc_far_clip.sv =====
`default_nettype none
module brc_far_clip (
   input  wire                      clock,
   input  brc_pkg::stage_en_type    en,
   input  brc_pkg::dims_type        dims,
   input  brc_pkg::geom_type        geom_in,
   output brc_pkg::geom_type        geom_out
);

   brc_pkg::geom_type        dest_far_in, dest_far_ff;
   brc_pkg::geom_type        src_far_in, src_far_ff;
   logic signed [brc_pkg::WIDE_W-1:0] dw_wide, dh_wide, sw_wide, sh_wide;
   logic signed [brc_pkg::WIDE_W-1:0] dest_right, dest_bottom, src_right, src_bottom;

   always_comb begin
      dw_wide     = brc_pkg::WIDE_W'(dims.dw);
      dh_wide     = brc_pkg::WIDE_W'(dims.dh);
      dest_right  = geom_in.dx + geom_in.w;
      dest_bottom = geom_in.dy + geom_in.h;
      dest_far_in = geom_in;
      dest_far_in.skip = geom_in.skip || brc_pkg::not_positive(geom_in.w) ||
                         brc_pkg::not_positive(geom_in.h);
      if ($signed(dest_right) > $signed(dw_wide)) begin
         dest_far_in.w = dw_wide - geom_in.dx;
      end
      if ($signed(dest_bottom) > $signed(dh_wide)) begin
         dest_far_in.h = dh_wide - geom_in.dy;
      end
   end

   always_comb begin
      sw_wide    = brc_pkg::WIDE_W'(dest_far_ff.sw);
      sh_wide    = brc_pkg::WIDE_W'(dest_far_ff.sh);
      src_right  = dest_far_ff.sx + dest_far_ff.w;
      src_bottom = dest_far_ff.sy + dest_far_ff.h;
      src_far_in = dest_far_ff;
      if (dest_far_ff.has_src && ($signed(src_right) > $signed(sw_wide))) begin
         src_far_in.w = sw_wide - dest_far_ff.sx;
      end
      if (dest_far_ff.has_src && ($signed(src_bottom) > $signed(sh_wide))) begin
         src_far_in.h = sh_wide - dest_far_ff.sy;
      end
   end

   always_ff @(posedge clock) begin
      if (en.load_a) begin
         dest_far_ff <= dest_far_in;
      end
      if (en.load_b) begin
         src_far_ff <= src_far_in;
      end
   end

   assign geom_out = src_far_ff;

endmodule
`default_nettype wire

// ===== src/brc_offset.sv =====
`default_nettype none
module brc_offset (
   input  wire                      clock,
   input  brc_pkg::stage_en_type    en,
   input  brc_pkg::dims_type        dims,
   input  brc_pkg::geom_type        geom,
   output brc_pkg::rsp_type         rsp
);

   typedef struct packed {
      logic                          skip;
      logic                          has_src;
      logic                          plain;
      logic                          walk_rows;
      logic                          walk_cols;
      logic [brc_pkg::FIELD_W-1:0]   dx;
      logic [brc_pkg::FIELD_W-1:0]   dy;
      logic [brc_pkg::FIELD_W-1:0]   sx;
      logic [brc_pkg::FIELD_W-1:0]   sy;
      logic [brc_pkg::FIELD_W-1:0]   w;
      logic [brc_pkg::FIELD_W-1:0]   h;
      logic [brc_pkg::COORD_W-1:0]   dest_row;
      logic [brc_pkg::COORD_W-1:0]   src_row;
   } product_type;

   product_type       product_in, product_ff;
   brc_pkg::rsp_type  rsp_in, rsp_ff;

   // after a clean clip every corner lies below 2^16, so 16 bits carry it exactly
   always_comb begin
      product_in.skip      = geom.skip || brc_pkg::not_positive(geom.w) ||
                             brc_pkg::not_positive(geom.h);
      product_in.has_src   = geom.has_src;
      product_in.plain     = geom.plain;
      product_in.dx        = geom.dx[brc_pkg::FIELD_W-1:0];
      product_in.dy        = geom.dy[brc_pkg::FIELD_W-1:0];
      product_in.sx        = geom.has_src ? geom.sx[brc_pkg::FIELD_W-1:0] : '0;
      product_in.sy        = geom.has_src ? geom.sy[brc_pkg::FIELD_W-1:0] : '0;
      product_in.w         = geom.w[brc_pkg::FIELD_W-1:0];
      product_in.h         = geom.h[brc_pkg::FIELD_W-1:0];
      product_in.walk_rows = geom.has_src && geom.same &&
                             (geom.dy[brc_pkg::FIELD_W-1:0] > geom.sy[brc_pkg::FIELD_W-1:0]);
      product_in.walk_cols = geom.has_src && geom.same &&
                             (geom.dx[brc_pkg::FIELD_W-1:0] > geom.sx[brc_pkg::FIELD_W-1:0]);
      product_in.dest_row  = brc_pkg::COORD_W'(geom.dy[brc_pkg::FIELD_W-1:0]) *
                             brc_pkg::COORD_W'(dims.dw);
      product_in.src_row   = brc_pkg::COORD_W'(geom.sy[brc_pkg::FIELD_W-1:0]) *
                             brc_pkg::COORD_W'(geom.sw);
   end

   always_comb begin
      rsp_in = '0;
      rsp_in.skip = product_ff.skip;
      if (!product_ff.skip) begin
         rsp_in.clip_dest_x        = product_ff.dx;
         rsp_in.clip_dest_y        = product_ff.dy;
         rsp_in.clip_source_x      = product_ff.sx;
         rsp_in.clip_source_y      = product_ff.sy;
         rsp_in.clip_width         = product_ff.w;
         rsp_in.clip_height        = product_ff.h;
         rsp_in.dest_offset        = product_ff.dest_row + brc_pkg::COORD_W'(product_ff.dx);
         rsp_in.source_offset      = product_ff.has_src ?
                                     product_ff.src_row + brc_pkg::COORD_W'(product_ff.sx) : '0;
         rsp_in.walk_rows_backward = product_ff.walk_rows;
         rsp_in.walk_cols_backward = product_ff.walk_cols;
         rsp_in.plain_copy         = product_ff.plain;
      end
   end

   always_ff @(posedge clock) begin
      if (en.load_a) begin
         product_ff <= product_in;
      end
      if (en.load_b) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule
`default_nettype wire

// ===== verif/brc_clip_checker.sv =====
module brc_clip_checker
   import brc_pkg::*;
(
   input  logic clock,
   input  logic reset,
   brc_req_if   req_ch,
   brc_rsp_if   rsp_ch,
   brc_csr_if   csr_ch,
   output int   mismatch_count,
   output int   results_owed
);

   logic [FIELD_W-1:0] surf_w;
   logic [FIELD_W-1:0] surf_h;
   rsp_type            owed_q[$];
   int                 errors = 0;
   int                 owed = 0;

   assign mismatch_count = errors;
   assign results_owed   = owed;

   function automatic rsp_type clip_command(input req_type c,
                                            input logic [FIELD_W-1:0] dw_r,
                                            input logic [FIELD_W-1:0] dh_r);
      longint dx, dy, sx, sy, w, h, sw, sh, dw, dh;
      bit     has_src;
      bit     plain;
      rsp_type r;
      r = '0;
      if (c.func == FUNC_RSVD || (c.func == FUNC_BLEND && c.blend_alpha == ALPHA_CLEAR)) begin
         r.skip = 1'b1;
         return r;
      end
      has_src = (c.func == FUNC_COPY) || (c.func == FUNC_BLEND);
      plain   = (c.func == FUNC_COPY) ||
                (c.func == FUNC_BLEND && c.blend_alpha == ALPHA_OPAQUE);
      dx = $signed(c.dest_corner_x);
      dy = $signed(c.dest_corner_y);
      sx = 0;
      sy = 0;
      if (has_src) begin
         sx = $signed(c.source_corner_x);
         sy = $signed(c.source_corner_y);
      end
      w  = c.rect_width;
      h  = c.rect_height;
      sw = c.source_surface_width;
      sh = c.source_surface_height;
      dw = dw_r;
      dh = dh_r;
      // near edges first, destination and source move together
      if (dx < 0) begin w += dx; sx -= dx; dx = 0; end
      if (dy < 0) begin h += dy; sy -= dy; dy = 0; end
      if (has_src) begin
         if (sx < 0) begin w += sx; dx -= sx; sx = 0; end
         if (sy < 0) begin h += sy; dy -= sy; sy = 0; end
      end
      if (w <= 0 || h <= 0) begin
         r.skip = 1'b1;
         return r;
      end
      if (dx + w > dw) w = dw - dx;
      if (dy + h > dh) h = dh - dy;
      if (has_src) begin
         if (sx + w > sw) w = sw - sx;
         if (sy + h > sh) h = sh - sy;
      end
      if (w <= 0 || h <= 0) begin
         r.skip = 1'b1;
         return r;
      end
      if (!has_src) begin
         sx = 0;
         sy = 0;
      end
      r.clip_dest_x   = FIELD_W'(dx);
      r.clip_dest_y   = FIELD_W'(dy);
      r.clip_source_x = FIELD_W'(sx);
      r.clip_source_y = FIELD_W'(sy);
      r.clip_width    = FIELD_W'(w);
      r.clip_height   = FIELD_W'(h);
      r.dest_offset   = COORD_W'(dy * dw + dx);
      if (has_src) begin
         r.source_offset      = COORD_W'(sy * sw + sx);
         r.walk_rows_backward = c.same_buffer && (dy > sy);
         r.walk_cols_backward = c.same_buffer && (dx > sx);
      end
      r.plain_copy = plain;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         errors++;
         $error("%s: expected %0h, got %0h", name, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      req_type cmd;
      rsp_type want;
      if (reset) begin
         surf_w = '0;
         surf_h = '0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               CSR_DEST_WIDTH:  surf_w = csr_ch.data;
               CSR_DEST_HEIGHT: surf_h = csr_ch.data;
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            cmd.func                  = func_type'(req_ch.func);
            cmd.dest_corner_x         = req_ch.dest_corner_x;
            cmd.dest_corner_y         = req_ch.dest_corner_y;
            cmd.source_corner_x       = req_ch.source_corner_x;
            cmd.source_corner_y       = req_ch.source_corner_y;
            cmd.rect_width            = req_ch.rect_width;
            cmd.rect_height           = req_ch.rect_height;
            cmd.source_surface_width  = req_ch.source_surface_width;
            cmd.source_surface_height = req_ch.source_surface_height;
            cmd.same_buffer           = req_ch.same_buffer;
            cmd.blend_alpha           = req_ch.blend_alpha;
            owed_q.push_back(clip_command(cmd, surf_w, surf_h));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (owed_q.size() == 0) begin
               errors++;
               $error("result transfer with no command outstanding");
            end else begin
               want = owed_q.pop_front();
               check_field("skip", want.skip, rsp_ch.skip);
               check_field("clip_dest_x", want.clip_dest_x, rsp_ch.clip_dest_x);
               check_field("clip_dest_y", want.clip_dest_y, rsp_ch.clip_dest_y);
               check_field("clip_source_x", want.clip_source_x, rsp_ch.clip_source_x);
               check_field("clip_source_y", want.clip_source_y, rsp_ch.clip_source_y);
               check_field("clip_width", want.clip_width, rsp_ch.clip_width);
               check_field("clip_height", want.clip_height, rsp_ch.clip_height);
               check_field("dest_offset", want.dest_offset, rsp_ch.dest_offset);
               check_field("source_offset", want.source_offset, rsp_ch.source_offset);
               check_field("walk_rows_backward", want.walk_rows_backward,
                           rsp_ch.walk_rows_backward);
               check_field("walk_cols_backward", want.walk_cols_backward,
                           rsp_ch.walk_cols_backward);
               check_field("plain_copy", want.plain_copy, rsp_ch.plain_copy);
            end
         end
      end
      owed = owed_q.size();
   end

endmodule

// ===== verif/tb.sv =====
module tb;
   import brc_pkg::*;

   localparam int STALL_LIMIT  = 5000;
   localparam int LONG_HOLD    = 300;
   localparam int PHASE_ITEMS  = 300;
   localparam int NUM_PHASES   = 6;
   localparam int CORNER_MIN   = 32'h8000_0000;
   localparam int CORNER_MAX   = 32'h7fff_ffff;
   localparam int unsigned SIZE_MAX = 32'hffff_ffff;

   logic clock;
   logic reset;

   brc_req_if req();
   brc_rsp_if rsp();
   brc_csr_if csr();

   int mismatch_count;
   int results_owed;
   int idle_cycles = 0;

   bit idle_on = 1'b0;
   bit hold_long = 1'b0;
   int unsigned surf_w = 0;
   int unsigned surf_h = 0;

   blit_rectangle_clipper_core i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req),
      .rsp_ch (rsp),
      .csr_ch (csr)
   );

   brc_clip_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req),
      .rsp_ch         (rsp),
      .csr_ch         (csr),
      .mismatch_count (mismatch_count),
      .results_owed   (results_owed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (csr.valid && csr.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // result side: random stalls, occasional long hold-off
   initial begin : drain_side
      int  stall;
      int  served;
      bit  rsp_idle_on;
      served = 0;
      rsp_idle_on = 1'b0;
      rsp.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (served % 40 == 0)
            rsp_idle_on = $urandom_range(0, 2) != 0;
         stall = rsp_idle_on ? $urandom_range(0, 17) : 0;
         if (hold_long) begin
            hold_long = 1'b0;
            stall = LONG_HOLD;
         end
         if (stall > 0) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         do @(posedge clock); while (!rsp.valid);
         served++;
      end
   end

   function automatic req_type build_command(input func_type f, input int dx, input int dy,
                                             input int sx, input int sy,
                                             input int unsigned w, input int unsigned h,
                                             input int unsigned sw, input int unsigned sh,
                                             input bit same, input int unsigned alpha);
      req_type c;
      c.func                  = f;
      c.dest_corner_x         = dx;
      c.dest_corner_y         = dy;
      c.source_corner_x       = sx;
      c.source_corner_y       = sy;
      c.rect_width            = w;
      c.rect_height           = h;
      c.source_surface_width  = FIELD_W'(sw);
      c.source_surface_height = FIELD_W'(sh);
      c.same_buffer           = same;
      c.blend_alpha           = ALPHA_W'(alpha);
      return c;
   endfunction

   function automatic req_type random_command(input int unsigned dw, input int unsigned dh);
      req_type     c;
      int unsigned pick;
      int unsigned sw, sh;
      pick = $urandom_range(0, 15);
      c.func = pick < 5 ? FUNC_FILL : pick < 10 ? FUNC_COPY : pick < 15 ? FUNC_BLEND : FUNC_RSVD;
      if ($urandom_range(0, 9) < 8) begin
         sw = $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 400);
         sh = $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 400);
         c.dest_corner_x   = int'($urandom_range(0, dw + 64)) - 32;
         c.dest_corner_y   = int'($urandom_range(0, dh + 64)) - 32;
         c.source_corner_x = int'($urandom_range(0, sw + 64)) - 32;
         c.source_corner_y = int'($urandom_range(0, sh + 64)) - 32;
         c.rect_width  = $urandom_range(0, 3) == 0 ? $urandom_range(0, dw + 64)
                                                   : $urandom_range(0, 48);
         c.rect_height = $urandom_range(0, 3) == 0 ? $urandom_range(0, dh + 64)
                                                   : $urandom_range(0, 48);
         c.source_surface_width  = FIELD_W'(sw);
         c.source_surface_height = FIELD_W'(sh);
         c.same_buffer = $urandom_range(0, 1);
         pick = $urandom_range(0, 3);
         c.blend_alpha = pick == 0 ? ALPHA_CLEAR : pick == 1 ? ALPHA_OPAQUE
                                                             : ALPHA_W'($urandom);
      end else begin
         c.dest_corner_x         = $urandom;
         c.dest_corner_y         = $urandom;
         c.source_corner_x       = $urandom;
         c.source_corner_y       = $urandom;
         c.rect_width            = $urandom;
         c.rect_height           = $urandom;
         c.source_surface_width  = FIELD_W'($urandom);
         c.source_surface_height = FIELD_W'($urandom);
         c.same_buffer           = $urandom_range(0, 1);
         c.blend_alpha           = ALPHA_W'($urandom);
      end
      return c;
   endfunction

   task automatic send_command(input req_type c);
      int gap;
      gap = idle_on ? $urandom_range(0, 17) : 0;
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid                 <= 1'b1;
      req.func                  <= c.func;
      req.dest_corner_x         <= c.dest_corner_x;
      req.dest_corner_y         <= c.dest_corner_y;
      req.source_corner_x       <= c.source_corner_x;
      req.source_corner_y       <= c.source_corner_y;
      req.rect_width            <= c.rect_width;
      req.rect_height           <= c.rect_height;
      req.source_surface_width  <= c.source_surface_width;
      req.source_surface_height <= c.source_surface_height;
      req.same_buffer           <= c.same_buffer;
      req.blend_alpha           <= c.blend_alpha;
      do @(posedge clock); while (!req.ready);
   endtask

   task automatic wait_results_done();
      req.valid <= 1'b0;
      do @(posedge clock); while (results_owed != 0);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [FIELD_W-1:0] value);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data  <= value;
      do @(posedge clock); while (!csr.ready);
   endtask

   task automatic set_surface(input int unsigned w, input int unsigned h);
      wait_results_done();
      write_reg(CSR_DEST_WIDTH, FIELD_W'(w));
      write_reg(CSR_DEST_HEIGHT, FIELD_W'(h));
      csr.valid <= 1'b0;
      surf_w = w;
      surf_h = h;
   endtask

   task automatic run_random(input int count, input bit squeeze);
      for (int i = 0; i < count; i++) begin
         if (i % 50 == 0)
            idle_on = $urandom_range(0, 2) != 0;
         if (squeeze && i == count / 4) begin
            idle_on = 1'b0;
            hold_long = 1'b1;
         end
         if (i == count / 2)
            wait_results_done();
         send_command(random_command(surf_w, surf_h));
      end
   endtask

   initial begin : stimulus
      int unsigned phase_w[NUM_PHASES];
      int unsigned phase_h[NUM_PHASES];
      phase_w = '{320, 65535, 1, 0, 640, 17};
      phase_h = '{240, 65535, 1, 200, 1, 65535};
      req.valid                 <= 1'b0;
      req.func                  <= FUNC_FILL;
      req.dest_corner_x         <= '0;
      req.dest_corner_y         <= '0;
      req.source_corner_x       <= '0;
      req.source_corner_y       <= '0;
      req.rect_width            <= '0;
      req.rect_height           <= '0;
      req.source_surface_width  <= '0;
      req.source_surface_height <= '0;
      req.same_buffer           <= 1'b0;
      req.blend_alpha           <= '0;
      csr.valid                 <= 1'b0;
      csr.index                 <= CSR_DEST_WIDTH;
      csr.data                  <= '0;
      reset                     <= 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // zero-sized destination straight out of reset
      send_command(build_command(FUNC_FILL, 0, 0, 0, 0, 1, 1, 0, 0, 0, 0));
      send_command(build_command(FUNC_COPY, 0, 0, 0, 0, 4, 4, 8, 8, 0, 0));

      set_surface(320, 240);
      idle_on = 1'b1;
      send_command(build_command(FUNC_FILL, 10, 20, 0, 0, 5, 6, 0, 0, 0, 0));
      send_command(build_command(FUNC_FILL, -5, -3, 7, 9, 20, 20, 0, 0, 1, 0));
      send_command(build_command(FUNC_FILL, 300, 230, 0, 0, 100, 100, 0, 0, 0, 0));
      send_command(build_command(FUNC_COPY, -4, 5, 10, -7, 30, 30, 64, 64, 0, 0));
      send_command(build_command(FUNC_COPY, 20, 30, 10, 10, 16, 16, 64, 64, 1, 0));
      send_command(build_command(FUNC_COPY, 5, 5, 20, 20, 16, 16, 64, 64, 1, 0));
      send_command(build_command(FUNC_BLEND, 8, 8, 0, 0, 10, 10, 64, 64, 0, 0));
      send_command(build_command(FUNC_BLEND, 8, 8, 3, 2, 10, 10, 64, 64, 1, 255));
      send_command(build_command(FUNC_BLEND, 8, 8, 3, 2, 10, 10, 64, 64, 0, 128));
      send_command(build_command(FUNC_RSVD, 1, 1, 1, 1, 10, 10, 64, 64, 1, 255));
      send_command(build_command(FUNC_FILL, 1, 1, 0, 0, 0, 10, 0, 0, 0, 0));
      send_command(build_command(FUNC_COPY, 1, 1, 0, 0, 10, 0, 64, 64, 0, 0));
      send_command(build_command(FUNC_FILL, CORNER_MIN, CORNER_MIN, CORNER_MAX, CORNER_MAX,
                                 SIZE_MAX, SIZE_MAX, 65535, 65535, 0, 0));
      send_command(build_command(FUNC_FILL, CORNER_MAX, CORNER_MAX, 0, 0,
                                 SIZE_MAX, SIZE_MAX, 0, 0, 0, 0));
      send_command(build_command(FUNC_COPY, 0, 0, 0, 0, 10, 10, 0, 0, 0, 0));
      send_command(build_command(FUNC_COPY, 0, 0, CORNER_MIN, CORNER_MIN,
                                 SIZE_MAX, SIZE_MAX, 65535, 65535, 1, 255));
      send_command(build_command(FUNC_COPY, 4, 4, 70, 2, 10, 10, 64, 64, 0, 0));
      send_command(build_command(FUNC_BLEND, 100, 50, 65000, 65000, 1000, 1000,
                                 65535, 65535, 1, 1));
      send_command(build_command(FUNC_FILL, 319, 239, 0, 0, 1, 1, 0, 0, 0, 0));
      send_command(build_command(FUNC_FILL, 320, 0, 0, 0, 1, 1, 0, 0, 0, 0));
      send_command(build_command(FUNC_COPY, CORNER_MAX, 0, CORNER_MIN, 0, SIZE_MAX, 5,
                                 65535, 65535, 1, 0));

      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p == 4)
            set_surface($urandom_range(1, 65535), $urandom_range(1, 65535));
         else
            set_surface(phase_w[p], phase_h[p]);
         run_random(PHASE_ITEMS, p == 0 || p == 2);
      end

      wait_results_done();
      repeat (2 * STAGES + 4) @(posedge clock);
      if (results_owed != 0)
         $error("%0d results never arrived", results_owed);
      if (mismatch_count == 0 && results_owed == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
